// File: design/colray_pkg.sv
package colray_pkg;

    localparam int ANGLE_BITS    = 12;
    localparam int FRAC_BITS     = 8;
    localparam int HALF_TURN     = 1 << (ANGLE_BITS - 1);
    localparam int QUARTER_TURN  = 1 << (ANGLE_BITS - 2);
    localparam int SIN_DEN_BASE  = 5 * HALF_TURN * HALF_TURN;
    localparam int SHADE_SCALE   = 765;
    localparam int MAP_CELLS_DEF = 4096;
    localparam int MAX_STEPS_DEF = 4096;

    localparam logic [2:0] CFG_SCREEN_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_SCREEN_HEIGHT = 3'd1;
    localparam logic [2:0] CFG_FIELD_OF_VIEW = 3'd2;
    localparam logic [2:0] CFG_TILE_SIZE     = 3'd3;
    localparam logic [2:0] CFG_MAP_WIDTH     = 3'd4;
    localparam logic [2:0] CFG_MAP_HEIGHT    = 3'd5;

    localparam logic [1:0] STATUS_WALL    = 2'd0;
    localparam logic [1:0] STATUS_OFF_MAP = 2'd1;
    localparam logic [1:0] STATUS_LIMIT   = 2'd2;
    localparam logic [1:0] STATUS_INSIDE  = 2'd3;

    localparam logic KIND_WRITE = 1'b0;

    typedef struct packed {
        logic        kind;
        logic [11:0] cell_index;
        logic        cell_wall;
        logic        cell_ok;
        logic [10:0] column;
        logic [19:0] player_x;
        logic [19:0] player_y;
        logic [11:0] player_angle;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } fwd_t;

    typedef struct packed {
        logic pop;
        logic clearing;
    } bwd_t;

    typedef struct packed {
        logic [11:0] screen_width;
        logic [11:0] screen_height;
        logic [10:0] field_of_view;
        logic [7:0]  tile_size;
        logic [6:0]  map_width;
        logic [6:0]  map_height;
    } cfg_t;

    typedef enum logic [4:0] {
        B_CLEAR,
        B_IDLE,
        B_ANG_MUL,
        B_ANG_DIV,
        B_ANG_WAIT,
        B_SIN_MUL,
        B_SIN_DIV,
        B_SIN_WAIT,
        B_CX_DIV,
        B_CX_WAIT,
        B_CY_DIV,
        B_CY_WAIT,
        B_ADDR,
        B_CHECK,
        B_STEP,
        B_DC_MUL,
        B_PROJ_DIV,
        B_PROJ_WAIT,
        B_SHADE_DIV,
        B_SHADE_WAIT,
        B_OUT
    } back_state_t;

endpackage

// File: design/colray_ram.sv
module colray_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: design/colray_div.sv
module colray_div #(
    parameter int NUM_W = 33,
    parameter int DEN_W = 25
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quot,
    output logic [DEN_W-1:0] rem
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W:0]   rem_shift;
    logic [DEN_W:0]   rem_diff;

    // One quotient bit per cycle, restoring form.
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[NUM_W-1]};
        rem_diff  = rem_shift - {1'b0, den_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W);
            quo_next  = num;
            rem_next  = '0;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            if (rem_shift >= {1'b0, den_reg})
            begin
                rem_next = rem_diff[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quot = quo_reg;
    assign rem  = rem_reg;

endmodule

// File: design/colray_front.sv
module colray_front #(
    parameter int MAP_CELLS = colray_pkg::MAP_CELLS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  colray_pkg::item_t  in_item,
    output logic               busy,
    output colray_pkg::fwd_t   fwd,
    input  colray_pkg::bwd_t   bwd
);

    colray_pkg::item_t q_mem [2];
    colray_pkg::item_t push_item;
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       accept;

    assign busy   = (count_reg == 2'd2) || bwd.clearing;
    assign accept = start && !busy;

    // Classify: flag map writes that land outside the map so they are dropped.
    always_comb
    begin
        push_item         = in_item;
        push_item.cell_ok = {20'd0, in_item.cell_index} < 32'(MAP_CELLS);
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (accept)
        begin
            wr_ptr_next = !wr_ptr_reg;
        end
        if (bwd.pop)
        begin
            rd_ptr_next = !rd_ptr_reg;
        end
        if (accept && !bwd.pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!accept && bwd.pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            q_mem[wr_ptr_reg] <= push_item;
        end
    end

    assign fwd.valid = (count_reg != 2'd0);
    assign fwd.item  = q_mem[rd_ptr_reg];

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        bwd.pop |-> count_reg != 2'd0)
        else $error("pop from empty queue");
    a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd2 && !bwd.pop) |=> count_reg == 2'd2)
        else $error("full queue grew or lost an entry");

endmodule

// File: design/colray_back.sv
module colray_back #(
    parameter int MAP_CELLS = colray_pkg::MAP_CELLS_DEF,
    parameter int MAX_STEPS = colray_pkg::MAX_STEPS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  colray_pkg::cfg_t  cfg,
    input  colray_pkg::fwd_t  fwd,
    output colray_pkg::bwd_t  bwd,
    output logic              result_strobe,
    output logic [10:0]       out_column,
    output logic [10:0]       ceiling_row,
    output logic [11:0]       floor_row,
    output logic [7:0]        shade,
    output logic [12:0]       distance_steps,
    output logic [19:0]       hit_x,
    output logic [19:0]       hit_y,
    output logic [1:0]        status
);

    localparam int ADDR_W = $clog2(MAP_CELLS);
    localparam int STEP_W = $clog2(MAX_STEPS + 1);
    localparam int POS_W  = ((STEP_W + colray_pkg::FRAC_BITS > 20) ?
                             STEP_W + colray_pkg::FRAC_BITS : 20) + 2;
    localparam int CELL_W = POS_W - colray_pkg::FRAC_BITS + 1;
    localparam int RX_W   = 8 + colray_pkg::FRAC_BITS;
    localparam int DC_W   = STEP_W + 11;
    localparam int NUM_W  = 33;
    localparam int DEN_W  = (DC_W + 1 > 25) ? DC_W + 1 : 25;
    localparam int IDX_W  = 14;

    colray_pkg::back_state_t state_reg, state_next;

    logic [ADDR_W-1:0]        clr_reg, clr_next;
    logic [10:0]              col_reg, col_next;
    logic [11:0]              pa_reg, pa_next;
    logic [11:0]              ray_reg, ray_next;
    logic [21:0]              prod_reg, prod_next;
    logic [1:0]               sel_reg, sel_next;
    logic                     neg_reg, neg_next;
    logic [20:0]              p_reg, p_next;
    logic signed [9:0]        dx_reg, dx_next;
    logic signed [9:0]        dy_reg, dy_next;
    logic signed [9:0]        cosc_reg, cosc_next;
    logic signed [POS_W-1:0]  px_reg, px_next;
    logic signed [POS_W-1:0]  py_reg, py_next;
    logic signed [CELL_W-1:0] cx_reg, cx_next;
    logic signed [CELL_W-1:0] cy_reg, cy_next;
    logic [RX_W-1:0]          rx_reg, rx_next;
    logic [RX_W-1:0]          ry_reg, ry_next;
    logic [STEP_W-1:0]        steps_reg, steps_next;
    logic                     off_reg, off_next;
    logic [1:0]               st_reg, st_next;
    logic signed [DC_W-1:0]   dc_reg, dc_next;
    logic [19:0]              ht_reg, ht_next;
    logic [17:0]              sh_reg, sh_next;
    logic [10:0]              ceil_reg, ceil_next;
    logic [7:0]               shade_reg, shade_next;
    logic                     strobe_reg, strobe_next;
    logic [10:0]              o_col_reg, o_col_next;
    logic [10:0]              o_ceil_reg, o_ceil_next;
    logic [11:0]              o_floor_reg, o_floor_next;
    logic [7:0]               o_shade_reg, o_shade_next;
    logic [12:0]              o_dist_reg, o_dist_next;
    logic [19:0]              o_hx_reg, o_hx_next;
    logic [19:0]              o_hy_reg, o_hy_next;
    logic [1:0]               o_st_reg, o_st_next;

    logic [11:0]        w_eff;
    logic [7:0]         tile_eff;
    logic [RX_W-1:0]    tw;
    logic [11:0]        sin_ang;
    logic [11:0]        hmt;
    logic signed [9:0]  sin_val;
    logic [IDX_W-1:0]   idx;
    logic               off_now;
    logic               dc_pos;
    logic [10:0]        half;
    logic signed [RX_W+1:0] rx_sum;
    logic signed [RX_W+1:0] ry_sum;

    logic               div_start, div_done;
    logic [NUM_W-1:0]   div_num, div_q;
    logic [DEN_W-1:0]   div_den, div_r;

    logic               ram_we, ram_wdata, ram_rdata;
    logic [ADDR_W-1:0]  ram_waddr, ram_raddr;

    colray_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_q),
        .rem   (div_r)
    );

    colray_ram #(.WIDTH(1), .DEPTH(MAP_CELLS)) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign w_eff    = (cfg.screen_width == 12'd0) ? 12'd1 : cfg.screen_width;
    assign tile_eff = (cfg.tile_size == 8'd0) ? 8'd1 : cfg.tile_size;
    assign tw       = RX_W'({tile_eff, {colray_pkg::FRAC_BITS{1'b0}}});
    assign half     = cfg.screen_height[11:1];
    assign dc_pos   = !dc_reg[DC_W-1] && (dc_reg != '0);

    always_comb
    begin
        case (sel_reg)
            2'd0:    sin_ang = ray_reg + 12'(colray_pkg::QUARTER_TURN);
            2'd1:    sin_ang = ray_reg;
            default: sin_ang = ray_reg - pa_reg + 12'(colray_pkg::QUARTER_TURN);
        endcase
        hmt = 12'(colray_pkg::HALF_TURN) - {1'b0, sin_ang[10:0]};
    end

    assign sin_val = neg_reg ? -$signed({1'b0, div_q[8:0]}) : $signed({1'b0, div_q[8:0]});

    // Map probe of the current cell.
    always_comb
    begin
        idx = IDX_W'(cx_reg[6:0]) + IDX_W'(cy_reg[6:0]) * IDX_W'(cfg.map_width);
        off_now = cx_reg[CELL_W-1] || cy_reg[CELL_W-1]
               || (cx_reg[CELL_W-2:0] >= (CELL_W-1)'(cfg.map_width))
               || (cy_reg[CELL_W-2:0] >= (CELL_W-1)'(cfg.map_height))
               || ({18'd0, idx} >= 32'(MAP_CELLS));
    end

    always_comb
    begin
        rx_sum = $signed({2'b00, rx_reg}) + (RX_W+2)'(dx_reg);
        ry_sum = $signed({2'b00, ry_reg}) + (RX_W+2)'(dy_reg);
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = clr_reg;
        ram_wdata = 1'b0;
        ram_raddr = ADDR_W'(idx);
        if (state_reg == colray_pkg::B_CLEAR)
        begin
            ram_we = 1'b1;
        end
        else if (state_reg == colray_pkg::B_IDLE && fwd.valid
                 && fwd.item.kind == colray_pkg::KIND_WRITE)
        begin
            ram_we    = fwd.item.cell_ok;
            ram_waddr = ADDR_W'(fwd.item.cell_index);
            ram_wdata = fwd.item.cell_wall;
        end
    end

    always_comb
    begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        case (state_reg)
            colray_pkg::B_ANG_DIV:
            begin
                div_start = 1'b1;
                div_num   = NUM_W'(prod_reg);
                div_den   = DEN_W'(w_eff);
            end
            colray_pkg::B_SIN_DIV:
            begin
                div_start = 1'b1;
                div_num   = NUM_W'(p_reg) << (colray_pkg::FRAC_BITS + 4);
                div_den   = DEN_W'(colray_pkg::SIN_DEN_BASE) - (DEN_W'(p_reg) << 2);
            end
            colray_pkg::B_CX_DIV:
            begin
                div_start = 1'b1;
                div_num   = NUM_W'(px_reg[19:0]);
                div_den   = DEN_W'(tw);
            end
            colray_pkg::B_CY_DIV:
            begin
                div_start = 1'b1;
                div_num   = NUM_W'(py_reg[19:0]);
                div_den   = DEN_W'(tw);
            end
            colray_pkg::B_PROJ_DIV:
            begin
                div_start = dc_pos;
                div_num   = NUM_W'(ht_reg) << colray_pkg::FRAC_BITS;
                div_den   = DEN_W'(dc_reg) << 1;
            end
            colray_pkg::B_SHADE_DIV:
            begin
                div_start = 1'b1;
                div_num   = NUM_W'(sh_reg) << colray_pkg::FRAC_BITS;
                div_den   = DEN_W'(dc_reg);
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    assign bwd.pop      = (state_reg == colray_pkg::B_IDLE) && fwd.valid;
    assign bwd.clearing = (state_reg == colray_pkg::B_CLEAR);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            colray_pkg::B_CLEAR:
                if (clr_reg == ADDR_W'(MAP_CELLS - 1))
                    state_next = colray_pkg::B_IDLE;
            colray_pkg::B_IDLE:
                if (fwd.valid && fwd.item.kind != colray_pkg::KIND_WRITE)
                    state_next = colray_pkg::B_ANG_MUL;
            colray_pkg::B_ANG_MUL:  state_next = colray_pkg::B_ANG_DIV;
            colray_pkg::B_ANG_DIV:  state_next = colray_pkg::B_ANG_WAIT;
            colray_pkg::B_ANG_WAIT:
                if (div_done)
                    state_next = colray_pkg::B_SIN_MUL;
            colray_pkg::B_SIN_MUL:  state_next = colray_pkg::B_SIN_DIV;
            colray_pkg::B_SIN_DIV:  state_next = colray_pkg::B_SIN_WAIT;
            colray_pkg::B_SIN_WAIT:
                if (div_done)
                    state_next = (sel_reg == 2'd2) ? colray_pkg::B_CX_DIV
                                                   : colray_pkg::B_SIN_MUL;
            colray_pkg::B_CX_DIV:   state_next = colray_pkg::B_CX_WAIT;
            colray_pkg::B_CX_WAIT:
                if (div_done)
                    state_next = colray_pkg::B_CY_DIV;
            colray_pkg::B_CY_DIV:   state_next = colray_pkg::B_CY_WAIT;
            colray_pkg::B_CY_WAIT:
                if (div_done)
                    state_next = colray_pkg::B_ADDR;
            colray_pkg::B_ADDR:     state_next = colray_pkg::B_CHECK;
            colray_pkg::B_CHECK:
                if (off_reg || ram_rdata || steps_reg == STEP_W'(MAX_STEPS))
                    state_next = colray_pkg::B_DC_MUL;
                else
                    state_next = colray_pkg::B_STEP;
            colray_pkg::B_STEP:     state_next = colray_pkg::B_ADDR;
            colray_pkg::B_DC_MUL:   state_next = colray_pkg::B_PROJ_DIV;
            colray_pkg::B_PROJ_DIV:
                state_next = dc_pos ? colray_pkg::B_PROJ_WAIT : colray_pkg::B_OUT;
            colray_pkg::B_PROJ_WAIT:
                if (div_done)
                    state_next = colray_pkg::B_SHADE_DIV;
            colray_pkg::B_SHADE_DIV: state_next = colray_pkg::B_SHADE_WAIT;
            colray_pkg::B_SHADE_WAIT:
                if (div_done)
                    state_next = colray_pkg::B_OUT;
            colray_pkg::B_OUT:      state_next = colray_pkg::B_IDLE;
            default:                state_next = colray_pkg::B_IDLE;
        endcase
    end

    // Datapath updates.
    always_comb
    begin
        clr_next     = clr_reg;
        col_next     = col_reg;
        pa_next      = pa_reg;
        ray_next     = ray_reg;
        prod_next    = prod_reg;
        sel_next     = sel_reg;
        neg_next     = neg_reg;
        p_next       = p_reg;
        dx_next      = dx_reg;
        dy_next      = dy_reg;
        cosc_next    = cosc_reg;
        px_next      = px_reg;
        py_next      = py_reg;
        cx_next      = cx_reg;
        cy_next      = cy_reg;
        rx_next      = rx_reg;
        ry_next      = ry_reg;
        steps_next   = steps_reg;
        off_next     = off_reg;
        st_next      = st_reg;
        dc_next      = dc_reg;
        ht_next      = ht_reg;
        sh_next      = sh_reg;
        ceil_next    = ceil_reg;
        shade_next   = shade_reg;
        strobe_next  = 1'b0;
        o_col_next   = o_col_reg;
        o_ceil_next  = o_ceil_reg;
        o_floor_next = o_floor_reg;
        o_shade_next = o_shade_reg;
        o_dist_next  = o_dist_reg;
        o_hx_next    = o_hx_reg;
        o_hy_next    = o_hy_reg;
        o_st_next    = o_st_reg;
        case (state_reg)
            colray_pkg::B_CLEAR:
                clr_next = clr_reg + 1'b1;
            colray_pkg::B_IDLE:
            begin
                col_next   = fwd.item.column;
                pa_next    = fwd.item.player_angle;
                px_next    = POS_W'({1'b0, fwd.item.player_x});
                py_next    = POS_W'({1'b0, fwd.item.player_y});
                sel_next   = 2'd0;
                steps_next = '0;
            end
            colray_pkg::B_ANG_MUL:
                prod_next = 22'(col_reg) * 22'(cfg.field_of_view);
            colray_pkg::B_ANG_WAIT:
                ray_next = pa_reg - 12'(cfg.field_of_view[10:1]) + div_q[11:0];
            colray_pkg::B_SIN_MUL:
            begin
                neg_next = sin_ang[11];
                p_next   = 21'(23'(sin_ang[10:0]) * 23'(hmt));
            end
            colray_pkg::B_SIN_WAIT:
                if (div_done)
                begin
                    sel_next = sel_reg + 2'd1;
                    case (sel_reg)
                        2'd0:    dx_next   = sin_val;
                        2'd1:    dy_next   = sin_val;
                        default: cosc_next = sin_val;
                    endcase
                end
            colray_pkg::B_CX_WAIT:
                if (div_done)
                begin
                    cx_next = CELL_W'(div_q);
                    rx_next = RX_W'(div_r);
                end
            colray_pkg::B_CY_WAIT:
                if (div_done)
                begin
                    cy_next = CELL_W'(div_q);
                    ry_next = RX_W'(div_r);
                end
            colray_pkg::B_ADDR:
                off_next = off_now;
            colray_pkg::B_CHECK:
                if (off_reg)
                    st_next = colray_pkg::STATUS_OFF_MAP;
                else if (ram_rdata)
                    st_next = (steps_reg == '0) ? colray_pkg::STATUS_INSIDE
                                                : colray_pkg::STATUS_WALL;
                else
                    st_next = colray_pkg::STATUS_LIMIT;
            colray_pkg::B_STEP:
            begin
                px_next    = px_reg + POS_W'(dx_reg);
                py_next    = py_reg + POS_W'(dy_reg);
                steps_next = steps_reg + 1'b1;
                if (rx_sum >= $signed({2'b00, tw}))
                begin
                    rx_next = RX_W'(rx_sum - $signed({2'b00, tw}));
                    cx_next = cx_reg + 1'b1;
                end
                else if (rx_sum < 0)
                begin
                    rx_next = RX_W'(rx_sum + $signed({2'b00, tw}));
                    cx_next = cx_reg - 1'b1;
                end
                else
                begin
                    rx_next = RX_W'(rx_sum);
                end
                if (ry_sum >= $signed({2'b00, tw}))
                begin
                    ry_next = RX_W'(ry_sum - $signed({2'b00, tw}));
                    cy_next = cy_reg + 1'b1;
                end
                else if (ry_sum < 0)
                begin
                    ry_next = RX_W'(ry_sum + $signed({2'b00, tw}));
                    cy_next = cy_reg - 1'b1;
                end
                else
                begin
                    ry_next = RX_W'(ry_sum);
                end
            end
            colray_pkg::B_DC_MUL:
            begin
                dc_next = DC_W'($signed({1'b0, steps_reg})) * DC_W'(cosc_reg);
                ht_next = 20'(cfg.screen_height) * 20'(tile_eff);
                sh_next = 18'(colray_pkg::SHADE_SCALE) * 18'(tile_eff);
            end
            colray_pkg::B_PROJ_DIV:
                if (!dc_pos)
                begin
                    ceil_next  = '0;
                    shade_next = 8'hFF;
                end
            colray_pkg::B_PROJ_WAIT:
                if (div_done)
                    ceil_next = (div_q >= NUM_W'(half)) ? 11'd0 : half - div_q[10:0];
            colray_pkg::B_SHADE_WAIT:
                if (div_done)
                    shade_next = (div_q > NUM_W'(255)) ? 8'hFF : div_q[7:0];
            colray_pkg::B_OUT:
            begin
                strobe_next  = 1'b1;
                o_col_next   = col_reg;
                o_ceil_next  = ceil_reg;
                o_floor_next = cfg.screen_height - 12'(ceil_reg);
                o_shade_next = shade_reg;
                o_dist_next  = 13'(steps_reg);
                o_hx_next    = px_reg[19:0];
                o_hy_next    = py_reg[19:0];
                o_st_next    = st_reg;
            end
            default:
                strobe_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= colray_pkg::B_CLEAR;
            clr_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg     <= col_next;
        pa_reg      <= pa_next;
        ray_reg     <= ray_next;
        prod_reg    <= prod_next;
        sel_reg     <= sel_next;
        neg_reg     <= neg_next;
        p_reg       <= p_next;
        dx_reg      <= dx_next;
        dy_reg      <= dy_next;
        cosc_reg    <= cosc_next;
        px_reg      <= px_next;
        py_reg      <= py_next;
        cx_reg      <= cx_next;
        cy_reg      <= cy_next;
        rx_reg      <= rx_next;
        ry_reg      <= ry_next;
        steps_reg   <= steps_next;
        off_reg     <= off_next;
        st_reg      <= st_next;
        dc_reg      <= dc_next;
        ht_reg      <= ht_next;
        sh_reg      <= sh_next;
        ceil_reg    <= ceil_next;
        shade_reg   <= shade_next;
        o_col_reg   <= o_col_next;
        o_ceil_reg  <= o_ceil_next;
        o_floor_reg <= o_floor_next;
        o_shade_reg <= o_shade_next;
        o_dist_reg  <= o_dist_next;
        o_hx_reg    <= o_hx_next;
        o_hy_reg    <= o_hy_next;
        o_st_reg    <= o_st_next;
    end

    assign result_strobe  = strobe_reg;
    assign out_column     = o_col_reg;
    assign ceiling_row    = o_ceil_reg;
    assign floor_row      = o_floor_reg;
    assign shade          = o_shade_reg;
    assign distance_steps = o_dist_reg;
    assign hit_x          = o_hx_reg;
    assign hit_y          = o_hy_reg;
    assign status         = o_st_reg;

    a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg |=> !strobe_reg)
        else $error("result strobe held longer than one cycle");
    a_check_after_addr: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == colray_pkg::B_CHECK |-> $past(state_reg) == colray_pkg::B_ADDR)
        else $error("map check without a prior address cycle");
    a_no_write_in_cast: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == colray_pkg::B_CLEAR || state_reg == colray_pkg::B_IDLE))
        else $error("map written during a cast");

endmodule

// File: design/column_raycaster_top.sv
// Column ray caster. A transaction with kind 0 writes one wall bit of the tile
// map and produces no result; a transaction with kind 1 casts the ray for one
// screen column and produces exactly one result, shown for a single cycle with
// result_strobe high. The receiver cannot stall: every result must be taken in
// the cycle it appears. A cast runs eight divisions through one shared serial
// divider (angle, three sine evaluations for the two ray components and the
// fish-eye cosine, the start cell's column and row, projection and shade), and
// each step of the march is one pass through the map memory's registered read
// port. When the corrected distance is not positive the projection and shade
// divisions are skipped. Two transactions can wait in the queue ahead of the
// caster, so start may be issued while a cast is still marching; busy rises
// while the queue is full and while the map is cleared. After reset the map,
// MAP_CELLS cells (4096 by default), is cleared one cell per cycle; busy stays
// high until the clear is done. Configuration writes are taken at any time but
// must only be made while the block is idle.
module column_raycaster_top #(
    parameter int MAP_CELLS = colray_pkg::MAP_CELLS_DEF,
    parameter int MAX_STEPS = colray_pkg::MAX_STEPS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        kind,
    input  logic [11:0] cell_index,
    input  logic        cell_wall,
    input  logic [10:0] column,
    input  logic [19:0] player_x,
    input  logic [19:0] player_y,
    input  logic [11:0] player_angle,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [11:0] cfg_wdata,
    output logic        result_strobe,
    output logic [10:0] out_column,
    output logic [10:0] ceiling_row,
    output logic [11:0] floor_row,
    output logic [7:0]  shade,
    output logic [12:0] distance_steps,
    output logic [19:0] hit_x,
    output logic [19:0] hit_y,
    output logic [1:0]  status
);

    colray_pkg::cfg_t  cfg_reg, cfg_next;
    colray_pkg::item_t in_item;
    colray_pkg::fwd_t  fwd;
    colray_pkg::bwd_t  bwd;

    // Register file: each register keeps only its own low bits.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                colray_pkg::CFG_SCREEN_WIDTH:  cfg_next.screen_width  = cfg_wdata;
                colray_pkg::CFG_SCREEN_HEIGHT: cfg_next.screen_height = cfg_wdata;
                colray_pkg::CFG_FIELD_OF_VIEW: cfg_next.field_of_view = cfg_wdata[10:0];
                colray_pkg::CFG_TILE_SIZE:     cfg_next.tile_size     = cfg_wdata[7:0];
                colray_pkg::CFG_MAP_WIDTH:     cfg_next.map_width     = cfg_wdata[6:0];
                colray_pkg::CFG_MAP_HEIGHT:    cfg_next.map_height    = cfg_wdata[6:0];
                default:                       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.screen_width  <= 12'd320;
            cfg_reg.screen_height <= 12'd240;
            cfg_reg.field_of_view <= 11'd683;
            cfg_reg.tile_size     <= 8'd16;
            cfg_reg.map_width     <= 7'd16;
            cfg_reg.map_height    <= 7'd16;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        in_item.kind         = kind;
        in_item.cell_index   = cell_index;
        in_item.cell_wall    = cell_wall;
        in_item.cell_ok      = 1'b0;
        in_item.column       = column;
        in_item.player_x     = player_x;
        in_item.player_y     = player_y;
        in_item.player_angle = player_angle;
    end

    // Front end: takes transactions and queues them for the caster.
    colray_front #(.MAP_CELLS(MAP_CELLS)) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .in_item (in_item),
        .busy    (busy),
        .fwd     (fwd),
        .bwd     (bwd)
    );

    // Back end: map clear after reset, map writes, the ray march, projection and shade.
    colray_back #(.MAP_CELLS(MAP_CELLS), .MAX_STEPS(MAX_STEPS)) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .fwd            (fwd),
        .bwd            (bwd),
        .result_strobe  (result_strobe),
        .out_column     (out_column),
        .ceiling_row    (ceiling_row),
        .floor_row      (floor_row),
        .shade          (shade),
        .distance_steps (distance_steps),
        .hit_x          (hit_x),
        .hit_y          (hit_y),
        .status         (status)
    );

endmodule
